// ----- hdl/pva_pkg.sv -----
`timescale 1ns / 1ps
// pva_pkg: shared types, operation codes and register indexes for the voice allocator
// used by pva_ctrl, pva_datapath and priority_voice_allocator; no dependencies

package pva_pkg;

  // fixed field widths
  localparam int GEN_W    = 24;
  localparam int IDX_W    = 8;
  localparam int HANDLE_W = 32;
  localparam int CLIP_W   = 6;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int PRIO_IN_W = 16;
  localparam int OUT_VOICE_W = 5;

  // number of clip slots; the loaded clip limit is capped at this value
  localparam int CLIPS = 64;

  // operation codes
  localparam logic [2:0] OP_PLAY        = 3'd0;
  localparam logic [2:0] OP_STOP        = 3'd1;
  localparam logic [2:0] OP_STOP_ALL    = 3'd2;
  localparam logic [2:0] OP_IS_PLAYING  = 3'd3;
  localparam logic [2:0] OP_VOICE_ENDED = 3'd4;
  localparam logic [2:0] OP_STEAL_QUERY = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LIMIT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_STEAL     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INSTANT_RELEASE = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the accepted item
    logic issue;     // read one voice entry this cycle
    logic use_ptr;   // read address from the scan pointer, else from the handle
    logic commit;    // final update for play and voice ended
    logic load_out;  // load the result register
  } pva_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan;      // op walks every voice
    logic direct;    // op reads the one voice named by the handle
  } pva_status_t;

  // generation advance: wraps at 24 bits and skips zero
  function automatic logic [GEN_W-1:0] next_gen(input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] n;
    n = g + GEN_W'(1);
    return (n == '0) ? GEN_W'(1) : n;
  endfunction

endpackage

// ----- hdl/pva_ram.sv -----
`timescale 1ns / 1ps
// pva_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/pva_datapath.sv -----
`timescale 1ns / 1ps
// pva_datapath: configuration registers, voice table ram, active and written flags,
// scan trackers and result register; depends on pva_pkg and pva_ram

module pva_datapath #(
  parameter int VOICES        = 16,
  parameter int PRIORITY_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          cfg_we,
  input  logic [pva_pkg::CFG_IDX_W-1:0]                 cfg_index,
  input  logic [pva_pkg::CFG_W-1:0]                     cfg_data,
  input  logic [2:0]                                    in_op,
  input  logic signed [pva_pkg::PRIO_IN_W-1:0]          in_priority_req,
  input  logic [pva_pkg::CLIP_W-1:0]                    in_clip_number,
  input  logic [pva_pkg::HANDLE_W-1:0]                  in_handle_in,
  input  logic [3:0]                                    in_ended_voice,
  input  pva_pkg::pva_cmd_t                             cmd,
  input  logic [$clog2(VOICES > 1 ? VOICES : 2)-1:0]    ptr,
  output pva_pkg::pva_status_t                          status,
  output logic [pva_pkg::HANDLE_W-1:0]                  out_handle_out,
  output logic                                          out_is_live,
  output logic signed [pva_pkg::OUT_VOICE_W-1:0]        out_steal_voice,
  output logic [pva_pkg::OUT_VOICE_W-1:0]               out_active_voices,
  output logic [31:0]                                   out_drops
);

  import pva_pkg::*;

  localparam int IW     = $clog2(VOICES > 1 ? VOICES : 2);
  localparam int CW     = $clog2(VOICES + 1);
  localparam int PW     = PRIORITY_BITS;
  localparam int WORD_W = GEN_W + PW + CLIP_W;

  // saturate the request priority to PW signed bits
  function automatic logic signed [PW-1:0] fit_priority(input logic signed [PRIO_IN_W-1:0] raw);
    logic signed [32:0] v;
    logic signed [32:0] hi;
    logic signed [32:0] lo;
    v  = 33'(raw);
    hi = (33'sd1 <<< (PW - 1)) - 33'sd1;
    lo = -hi - 33'sd1;
    if (v > hi) begin
      v = hi;
    end else if (v < lo) begin
      v = lo;
    end
    return PW'(v);
  endfunction

  // configuration
  logic             enabled_r;
  logic [CFG_W-1:0] clip_limit_r;
  logic             allow_steal_r;
  logic             instant_release_r;

  // captured item
  logic [2:0]           op_r;
  logic signed [PW-1:0] prio_r;
  logic [CLIP_W-1:0]    clip_r;
  logic [HANDLE_W-1:0]  handle_r;
  logic [3:0]           ended_r;

  // voice flags and counters
  logic [VOICES-1:0] active_r, active_nxt;
  logic [VOICES-1:0] written_r, written_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [31:0]       drops_r, drops_nxt;

  // evaluation stage behind the ram read
  logic          ev_vld_r;
  logic [IW-1:0] ev_idx_r;

  // scan trackers and results
  logic                 free_found_r, free_found_nxt;
  logic [IW-1:0]        free_idx_r, free_idx_nxt;
  logic [GEN_W-1:0]     free_gen_r, free_gen_nxt;
  logic                 vic_found_r, vic_found_nxt;
  logic [IW-1:0]        vic_idx_r, vic_idx_nxt;
  logic [GEN_W-1:0]     vic_gen_r, vic_gen_nxt;
  logic signed [PW-1:0] lowest_r, lowest_nxt;
  logic                 live_r, live_nxt;
  logic [HANDLE_W-1:0]  handle_res_r, handle_res_nxt;

  // ram ports
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // handle decode
  logic [IDX_W-1:0] hlow;
  logic             h_ok;
  logic [IW-1:0]    h_idx;

  // evaluated entry
  logic                 ev_act;
  logic [GEN_W-1:0]     rd_gen;
  logic signed [PW-1:0] rd_prio;
  logic [GEN_W-1:0]     ev_gen;
  logic                 ev_hit;
  logic                 ev_release;
  logic [WORD_W-1:0]    rel_word;

  // play decision
  logic [12:0]      cc;
  logic             play_ok;
  logic             take_free;
  logic             take_steal;
  logic [IW-1:0]    ch_idx;
  logic [GEN_W-1:0] ch_gen;
  logic             ended_ok;
  logic [IW-1:0]    ended_idx;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r         <= 1'b0;
      clip_limit_r      <= '0;
      allow_steal_r     <= 1'b0;
      instant_release_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLED:         enabled_r         <= cfg_data[0];
        CFG_CLIP_LIMIT:      clip_limit_r      <= cfg_data;
        CFG_ALLOW_STEAL:     allow_steal_r     <= cfg_data[0];
        CFG_INSTANT_RELEASE: instant_release_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_op;
      prio_r   <= fit_priority(in_priority_req);
      clip_r   <= in_clip_number;
      handle_r <= in_handle_in;
      ended_r  <= in_ended_voice;
    end
  end

  // op class for the controller
  assign status.scan   = op_r inside {OP_PLAY, OP_STOP_ALL, OP_STEAL_QUERY};
  assign status.direct = op_r inside {OP_STOP, OP_IS_PLAYING};

  // handle low byte selects voice index plus one
  assign hlow  = handle_r[IDX_W-1:0];
  assign h_ok  = (hlow != '0) && (9'(hlow) <= 9'(VOICES));
  assign h_idx = IW'(hlow - 8'd1);

  assign ram_raddr = cmd.use_ptr ? ptr : h_idx;

  pva_ram #(
    .WIDTH(WORD_W),
    .DEPTH(VOICES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // entry fields; an entry never written reads as generation one
  assign rd_gen  = ram_rdata[WORD_W-1 -: GEN_W];
  assign rd_prio = ram_rdata[CLIP_W +: PW];
  assign ev_act  = active_r[ev_idx_r];
  assign ev_gen  = written_r[ev_idx_r] ? rd_gen : GEN_W'(1);
  assign ev_hit  = h_ok && ev_act && (handle_r[HANDLE_W-1:IDX_W] == ev_gen);

  assign ev_release = ev_vld_r && (((op_r == OP_STOP_ALL) && ev_act) ||
                                   ((op_r == OP_STOP) && ev_hit));
  assign rel_word = {next_gen(ev_gen),
                     instant_release_r ? ram_rdata[CLIP_W +: PW] : {PW{1'b0}},
                     ram_rdata[CLIP_W-1:0]};

  // play decision after the scan
  assign cc = (13'(clip_limit_r) > 13'(CLIPS)) ? 13'(CLIPS) : 13'(clip_limit_r);
  assign play_ok    = enabled_r && (13'(clip_r) < cc);
  assign take_free  = play_ok && free_found_r;
  assign take_steal = play_ok && !free_found_r && allow_steal_r && vic_found_r;
  assign ch_idx     = free_found_r ? free_idx_r : vic_idx_r;
  assign ch_gen     = next_gen(free_found_r ? free_gen_r : vic_gen_r);

  assign ended_ok  = 9'(ended_r) < 9'(VOICES);
  assign ended_idx = IW'(ended_r);

  // next state of flags, counters and trackers
  always_comb begin
    active_nxt     = active_r;
    written_nxt    = written_r;
    count_nxt      = count_r;
    drops_nxt      = drops_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    free_gen_nxt   = free_gen_r;
    vic_found_nxt  = vic_found_r;
    vic_idx_nxt    = vic_idx_r;
    vic_gen_nxt    = vic_gen_r;
    lowest_nxt     = lowest_r;
    live_nxt       = live_r;
    handle_res_nxt = handle_res_r;
    ram_we         = 1'b0;
    ram_waddr      = ev_idx_r;
    ram_wdata      = rel_word;

    // fresh item
    if (cmd.capture) begin
      free_found_nxt = 1'b0;
      vic_found_nxt  = 1'b0;
      lowest_nxt     = fit_priority(in_priority_req);
      live_nxt       = 1'b0;
      handle_res_nxt = '0;
    end

    // one voice entry per cycle
    if (ev_vld_r) begin
      case (op_r)
        OP_PLAY, OP_STEAL_QUERY: begin
          if (!ev_act && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = ev_idx_r;
            free_gen_nxt   = ev_gen;
          end
          if (ev_act && (rd_prio < lowest_r)) begin
            vic_found_nxt = 1'b1;
            vic_idx_nxt   = ev_idx_r;
            vic_gen_nxt   = ev_gen;
            lowest_nxt    = rd_prio;
          end
        end
        OP_IS_PLAYING: begin
          live_nxt = ev_hit;
        end
        default: ;
      endcase
    end

    // retire a handle: bump generation, then free or silence
    if (ev_release) begin
      ram_we = 1'b1;
      if (instant_release_r) begin
        active_nxt[ev_idx_r] = 1'b0;
        count_nxt            = count_r - CW'(1);
      end
    end

    // final update
    if (cmd.commit) begin
      case (op_r)
        OP_PLAY: begin
          if (take_free || take_steal) begin
            ram_we              = 1'b1;
            ram_waddr           = ch_idx;
            ram_wdata           = {ch_gen, prio_r, clip_r};
            active_nxt[ch_idx]  = 1'b1;
            written_nxt[ch_idx] = 1'b1;
            handle_res_nxt      = {ch_gen, 8'(ch_idx) + 8'd1};
            if (take_free) begin
              count_nxt = count_r + CW'(1);
            end
          end else if (play_ok) begin
            drops_nxt = drops_r + 32'd1;
          end
        end
        OP_VOICE_ENDED: begin
          if (ended_ok && active_r[ended_idx]) begin
            active_nxt[ended_idx] = 1'b0;
            count_nxt             = count_r - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= '0;
      written_r <= '0;
      count_r   <= '0;
      drops_r   <= '0;
      ev_vld_r  <= 1'b0;
    end else begin
      active_r  <= active_nxt;
      written_r <= written_nxt;
      count_r   <= count_nxt;
      drops_r   <= drops_nxt;
      ev_vld_r  <= cmd.issue;
    end
  end

  // trackers and evaluation index
  always_ff @(posedge clk) begin
    ev_idx_r     <= ram_raddr;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    free_gen_r   <= free_gen_nxt;
    vic_found_r  <= vic_found_nxt;
    vic_idx_r    <= vic_idx_nxt;
    vic_gen_r    <= vic_gen_nxt;
    lowest_r     <= lowest_nxt;
    live_r       <= live_nxt;
    handle_res_r <= handle_res_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_handle_out    <= handle_res_r;
      out_is_live       <= live_r;
      out_steal_voice   <= ((op_r == OP_STEAL_QUERY) && vic_found_r) ?
                           OUT_VOICE_W'(vic_idx_r) : {OUT_VOICE_W{1'b1}};
      out_active_voices <= OUT_VOICE_W'(count_r);
      out_drops         <= drops_r;
    end
  end

endmodule

// ----- hdl/pva_ctrl.sv -----
`timescale 1ns / 1ps
// pva_ctrl: sequencer for the voice allocator, drives the scan pointer and commands
// depends on pva_pkg

module pva_ctrl #(
  parameter int VOICES = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  input  pva_pkg::pva_status_t                        status,
  output pva_pkg::pva_cmd_t                           cmd,
  output logic [$clog2(VOICES > 1 ? VOICES : 2)-1:0]  ptr
);

  import pva_pkg::*;

  localparam int IW = $clog2(VOICES > 1 ? VOICES : 2);
  localparam logic [IW-1:0] LAST = IW'(VOICES - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] ptr_r, ptr_nxt;
  logic          out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign ptr       = ptr_r;

  // sequencing
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;

    // result leaves on a transfer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          ptr_nxt     = '0;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        if (status.scan) begin
          cmd.issue   = 1'b1;
          cmd.use_ptr = 1'b1;
          if (ptr_r == LAST) begin
            state_nxt = S_DRAIN;
          end else begin
            ptr_nxt = ptr_r + IW'(1);
          end
        end else if (status.direct) begin
          cmd.issue = 1'b1;
          state_nxt = S_DRAIN;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hdl/priority_voice_allocator.sv -----
`timescale 1ns / 1ps
// priority_voice_allocator: voice table with priorities, stealing and generation handles
// operation: play, stop all and steal query walk the voice table one entry per cycle through
// the ram read port; stop and is playing read the one voice named by the handle, voice
// ended and unused ops read no entry; one item at a time, the next transfer in is taken
// the cycle after the result is loaded
// reset: synchronous, active low; all voices free, generations 1, drop count 0, no clearing pass

module priority_voice_allocator #(
  parameter int VOICES        = 16,
  parameter int PRIORITY_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // configuration
  input  logic                                    cfg_we,
  input  logic [pva_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [pva_pkg::CFG_W-1:0]               cfg_data,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [2:0]                              in_op,
  input  logic signed [pva_pkg::PRIO_IN_W-1:0]    in_priority_req,
  input  logic [pva_pkg::CLIP_W-1:0]              in_clip_number,
  input  logic [pva_pkg::HANDLE_W-1:0]            in_handle_in,
  input  logic [3:0]                              in_ended_voice,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [pva_pkg::HANDLE_W-1:0]            out_handle_out,
  output logic                                    out_is_live,
  output logic signed [pva_pkg::OUT_VOICE_W-1:0]  out_steal_voice,
  output logic [pva_pkg::OUT_VOICE_W-1:0]         out_active_voices,
  output logic [31:0]                             out_drops
);

  import pva_pkg::*;

  localparam int IW = $clog2(VOICES > 1 ? VOICES : 2);

  pva_cmd_t      cmd;
  pva_status_t   status;
  logic [IW-1:0] ptr;

  pva_ctrl #(
    .VOICES(VOICES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd),
    .ptr      (ptr)
  );

  pva_datapath #(
    .VOICES       (VOICES),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_op            (in_op),
    .in_priority_req  (in_priority_req),
    .in_clip_number   (in_clip_number),
    .in_handle_in     (in_handle_in),
    .in_ended_voice   (in_ended_voice),
    .cmd              (cmd),
    .ptr              (ptr),
    .status           (status),
    .out_handle_out   (out_handle_out),
    .out_is_live      (out_is_live),
    .out_steal_voice  (out_steal_voice),
    .out_active_voices(out_active_voices),
    .out_drops        (out_drops)
  );

  // result register is loaded only when it is free or leaving
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result loaded over a waiting result");

  // a fresh handle never names voice zero or generation zero, and comes alone
  a_handle_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_handle_out != '0)) |->
      ((out_handle_out[31:8] != '0) && (out_handle_out[7:0] != '0) &&
       (out_steal_voice == 5'h1F) && !out_is_live))
    else $error("malformed play result");

  // active count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((VOICES > 31) || (32'(out_active_voices) <= 32'(VOICES))))
    else $error("active voice count out of range");

  // an accepted item holds off the next one while it is worked on
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while busy");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking testbench for the priority voice allocator
// drives directed and random voice commands, predicts every reply in-bench
// and compares field by field; depends on pva_pkg and priority_voice_allocator

module tb_top;
  import pva_pkg::*;

  localparam int NUM_VOICES = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 40;
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  typedef struct {
    logic [2:0]         op;
    logic signed [15:0] prio;
    logic [5:0]         clip;
    logic [31:0]        handle;
    logic [3:0]         ended;
  } voice_cmd_t;

  typedef struct {
    logic [31:0]       handle;
    logic              live;
    logic signed [4:0] steal;
    logic [4:0]        active;
    logic [31:0]       drops;
  } voice_reply_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_op = '0;
  logic signed [PRIO_IN_W-1:0] in_priority_req = '0;
  logic [CLIP_W-1:0] in_clip_number = '0;
  logic [HANDLE_W-1:0] in_handle_in = '0;
  logic [3:0] in_ended_voice = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [HANDLE_W-1:0] out_handle_out;
  logic out_is_live;
  logic signed [OUT_VOICE_W-1:0] out_steal_voice;
  logic [OUT_VOICE_W-1:0] out_active_voices;
  logic [31:0] out_drops;

  priority_voice_allocator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_priority_req  (in_priority_req),
    .in_clip_number   (in_clip_number),
    .in_handle_in     (in_handle_in),
    .in_ended_voice   (in_ended_voice),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_handle_out   (out_handle_out),
    .out_is_live      (out_is_live),
    .out_steal_voice  (out_steal_voice),
    .out_active_voices(out_active_voices),
    .out_drops        (out_drops)
  );

  // shadow copy of the voice table and the registers
  logic               sh_enabled = 1'b0;
  logic [6:0]         sh_clips = '0;
  logic               sh_steal = 1'b0;
  logic               sh_instant = 1'b1;
  logic               vact [NUM_VOICES];
  logic signed [15:0] vprio [NUM_VOICES];
  logic [5:0]         vclip [NUM_VOICES];
  logic [23:0]        vgen [NUM_VOICES];
  logic [31:0]        drop_total = '0;

  voice_cmd_t   cmd_q [$];
  voice_reply_t reply_q [$];
  logic [31:0]  issued_handles [$];
  voice_cmd_t   cur_cmd;
  voice_reply_t pred_reply;
  voice_reply_t want;
  int errs = 0;
  int cycles = 0;
  int snd_idle_pct = 31;
  int rcv_idle_pct = 59;

  initial begin
    for (int i = 0; i < NUM_VOICES; i++) begin
      vact[i] = 1'b0;
      vprio[i] = '0;
      vclip[i] = '0;
      vgen[i] = 24'd1;
    end
  end

  // generation advance, wrapping past zero
  function automatic logic [23:0] advance_gen(logic [23:0] g);
    return (g == 24'hFFFFFF) ? 24'd1 : g + 24'd1;
  endfunction

  // first active voice with the lowest priority strictly below prio
  function automatic int lowest_below(logic signed [15:0] prio);
    int victim;
    logic signed [15:0] low;
    victim = -1;
    low = prio;
    for (int i = 0; i < NUM_VOICES; i++) begin
      if (vact[i] && vprio[i] < low) begin
        low = vprio[i];
        victim = i;
      end
    end
    return victim;
  endfunction

  // voice a handle names, or -1 when stale or malformed
  function automatic int find_voice(logic [31:0] h);
    int idx;
    if (h[7:0] == 8'd0 || h[7:0] > NUM_VOICES) return -1;
    idx = int'(h[7:0]) - 1;
    if (!vact[idx] || h[31:8] != vgen[idx]) return -1;
    return idx;
  endfunction

  function automatic void retire_voice(int v);
    vgen[v] = advance_gen(vgen[v]);
    if (sh_instant) vact[v] = 1'b0;
    else vprio[v] = '0;
  endfunction

  // apply one command to the shadow table and return the reply it yields
  function automatic voice_reply_t allocator_step(voice_cmd_t c);
    voice_reply_t r;
    int v;
    int cnt;
    logic [6:0] cap;
    r.handle = '0;
    r.live = 1'b0;
    r.steal = -5'sd1;
    case (c.op)
      OP_PLAY: begin
        cap = (sh_clips > CLIPS) ? 7'(CLIPS) : sh_clips;
        if (sh_enabled && {1'b0, c.clip} < cap) begin
          v = -1;
          for (int i = NUM_VOICES - 1; i >= 0; i--) begin
            if (!vact[i]) v = i;
          end
          if (v < 0 && sh_steal) v = lowest_below(c.prio);
          if (v < 0) begin
            drop_total = drop_total + 32'd1;
          end else begin
            vgen[v] = advance_gen(vgen[v]);
            vact[v] = 1'b1;
            vprio[v] = c.prio;
            vclip[v] = c.clip;
            r.handle = {vgen[v], 8'(v + 1)};
          end
        end
      end
      OP_STOP: begin
        v = find_voice(c.handle);
        if (v >= 0) retire_voice(v);
      end
      OP_STOP_ALL: begin
        for (int i = 0; i < NUM_VOICES; i++) begin
          if (vact[i]) retire_voice(i);
        end
      end
      OP_IS_PLAYING: r.live = (find_voice(c.handle) >= 0);
      OP_VOICE_ENDED: begin
        if (c.ended < NUM_VOICES) vact[c.ended] = 1'b0;
      end
      OP_STEAL_QUERY: r.steal = 5'(lowest_below(c.prio));
      default: ;
    endcase
    cnt = 0;
    for (int i = 0; i < NUM_VOICES; i++) begin
      if (vact[i]) cnt++;
    end
    r.active = 5'(cnt);
    r.drops = drop_total;
    return r;
  endfunction

  // clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // command driver: predicts each transfer in, then presents the next command
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pred_reply = allocator_step(cur_cmd);
        reply_q.push_back(pred_reply);
        if (pred_reply.handle != '0) begin
          issued_handles.push_back(pred_reply.handle);
          if (issued_handles.size() > 32) void'(issued_handles.pop_front());
        end
      end
      if (!in_valid || !in_stall) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
          cur_cmd = cmd_q.pop_front();
          in_op <= cur_cmd.op;
          in_priority_req <= cur_cmd.prio;
          in_clip_number <= cur_cmd.clip;
          in_handle_in <= cur_cmd.handle;
          in_ended_voice <= cur_cmd.ended;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_idle_pct);
  end

  task automatic check_field(string fld, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errs++;
      if (errs <= MAX_REPORTS)
        $display("%0t: %s expected %h actual %h", $time, fld, exp_v, act_v);
    end
  endtask

  // reply monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (reply_q.size() == 0) begin
        errs++;
        if (errs <= MAX_REPORTS)
          $display("%0t: reply with none pending, expected nothing actual handle %h",
                   $time, out_handle_out);
      end else begin
        want = reply_q.pop_front();
        check_field("handle_out", want.handle, out_handle_out);
        check_field("is_live", want.live, out_is_live);
        check_field("steal_voice", want.steal, out_steal_voice);
        check_field("active_voices", want.active, out_active_voices);
        check_field("drops", want.drops, out_drops);
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ENABLED:         sh_enabled = val[0];
      CFG_CLIP_LIMIT:      sh_clips = val;
      CFG_ALLOW_STEAL:     sh_steal = val[0];
      CFG_INSTANT_RELEASE: sh_instant = val[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic en, logic [6:0] cc, logic st, logic ir);
    cfg_write(CFG_ENABLED, 7'(en));
    cfg_write(CFG_CLIP_LIMIT, cc);
    cfg_write(CFG_ALLOW_STEAL, 7'(st));
    cfg_write(CFG_INSTANT_RELEASE, 7'(ir));
    @(negedge clk);
  endtask

  // wait until every command is through and every reply is back
  task automatic drain();
    @(negedge clk);
    while (cmd_q.size() != 0 || reply_q.size() != 0 || in_valid) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic push_cmd(logic [2:0] op, logic signed [15:0] prio, logic [5:0] clip,
                          logic [31:0] h, logic [3:0] ev);
    voice_cmd_t c;
    c.op = op;
    c.prio = prio;
    c.clip = clip;
    c.handle = h;
    c.ended = ev;
    cmd_q.push_back(c);
  endtask

  // handle mix: live ones, recently issued ones, malformed and random
  function automatic logic [31:0] pick_handle();
    int r;
    int i;
    logic [31:0] h;
    r = $urandom_range(99);
    h = $urandom();
    if (r < 55) begin
      i = $urandom_range(NUM_VOICES - 1);
      h = {vgen[i], 8'(i + 1)};
    end else if (r < 70 && issued_handles.size() > 0) begin
      h = issued_handles[$urandom_range(issued_handles.size() - 1)];
    end else if (r < 85) begin
      h[7:0] = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, NUM_VOICES + 1));
    end
    return h;
  endfunction

  function automatic logic signed [15:0] pick_prio();
    logic [31:0] raw;
    raw = $urandom();
    if ($urandom_range(99) < 30) return 16'(int'($urandom_range(6)) - 3);
    return raw[15:0];
  endfunction

  task automatic push_random_cmd();
    int r;
    logic [2:0] op;
    r = $urandom_range(99);
    if (r < 40) op = OP_PLAY;
    else if (r < 55) op = OP_STOP;
    else if (r < 56) op = OP_STOP_ALL;
    else if (r < 70) op = OP_IS_PLAYING;
    else if (r < 80) op = OP_VOICE_ENDED;
    else if (r < 95) op = OP_STEAL_QUERY;
    else if (r < 98) op = OP_UNUSED_6;
    else op = OP_UNUSED_7;
    push_cmd(op, pick_prio(), 6'($urandom_range(63)), pick_handle(),
             4'($urandom_range(NUM_VOICES - 1)));
  endtask

  // register settings per random phase
  logic       ph_en [8] = '{1, 1, 1, 1, 0, 1, 1, 1};
  logic [6:0] ph_cc [8] = '{64, 64, 127, 1, 64, 33, 0, 64};
  logic       ph_st [8] = '{1, 0, 1, 0, 1, 1, 1, 1};
  logic       ph_ir [8] = '{1, 0, 0, 1, 1, 0, 1, 0};

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: play refused, unused ops
    push_cmd(OP_PLAY, 16'sd0, 6'd0, 32'd0, 4'd0);
    push_cmd(OP_UNUSED_6, 16'sd5, 6'd1, 32'h0000_0201, 4'd1);
    push_cmd(OP_UNUSED_7, -16'sd5, 6'd2, 32'hFFFF_FFFF, 4'd15);
    drain();

    // fill every voice, then steal the lowest and drop a bottom-priority play
    set_regs(1'b1, 7'd64, 1'b1, 1'b0);
    for (int i = 0; i < NUM_VOICES; i++) begin
      push_cmd(OP_PLAY, (i == 0) ? -16'sd32768 : (i == 1) ? 16'sd32767 : 16'(i),
               (i == NUM_VOICES - 1) ? 6'd63 : 6'(i * 4), 32'd0, 4'd0);
    end
    push_cmd(OP_PLAY, 16'sd32767, 6'd5, 32'd0, 4'd0);
    push_cmd(OP_PLAY, -16'sd32768, 6'd6, 32'd0, 4'd0);
    drain();

    // handle checks, delayed release, stop all, end of sample
    push_cmd(OP_STEAL_QUERY, 16'sd32767, 6'd0, 32'd0, 4'd0);
    push_cmd(OP_IS_PLAYING, 16'sd0, 6'd0, {vgen[1], 8'd2}, 4'd0);
    push_cmd(OP_STOP, 16'sd0, 6'd0, {vgen[1], 8'd2}, 4'd0);
    push_cmd(OP_IS_PLAYING, 16'sd0, 6'd0, {vgen[1], 8'd2}, 4'd0);
    push_cmd(OP_STOP_ALL, 16'sd0, 6'd0, 32'd0, 4'd0);
    push_cmd(OP_VOICE_ENDED, 16'sd0, 6'd0, 32'd0, 4'd15);
    push_cmd(OP_VOICE_ENDED, 16'sd0, 6'd0, 32'd0, 4'd0);
    push_cmd(OP_IS_PLAYING, 16'sd0, 6'd0, 32'hFFFF_FF00, 4'd0);
    drain();

    // random phases over the register settings and idling mixes
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        snd_idle_pct = 59;
        rcv_idle_pct = 31;
      end else if (ph == 6) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      set_regs(ph_en[ph], ph_cc[ph], ph_st[ph], ph_ir[ph]);
      for (int n = 0; n < 130; n++) begin
        while (cmd_q.size() >= 4) @(negedge clk);
        push_random_cmd();
      end
      drain();
    end

    repeat (30) @(posedge clk);
    if (errs == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/pva_pkg.sv
hdl/pva_ram.sv
hdl/pva_datapath.sv
hdl/pva_ctrl.sv
hdl/priority_voice_allocator.sv
sim/tb_top.sv
